@@ hw/rtl/bba_pkg.sv @@
`timescale 1ns / 1ps

package bba_pkg;

   localparam int CNT_W      = 13;   // block count register
   localparam int BLK_W      = 12;   // block index on the ports
   localparam int STAT_W     = 2;
   localparam int TDATA_W    = 16;
   localparam int WORD_W     = 64;   // bitmap memory row
   localparam int BIT_IDX_W  = 6;    // bit within a row
   localparam int LANE_W     = 8;    // width of the zero finder
   localparam int LANE_IDX_W = 3;

   localparam logic [CNT_W-1:0] CNT_RESET = 13'd4096;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK          = 2'd0,
      STAT_NO_FREE     = 2'd1,
      STAT_DOUBLE_FREE = 2'd2,
      STAT_RANGE       = 2'd3
   } status_type;

   typedef struct packed {
      status_type       status;
      logic [BLK_W-1:0] granted;
   } resp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_WORD,
      ST_FCHECK,
      ST_DONE
   } state_type;

endpackage

@@ hw/rtl/bba_ram.sv @@
`timescale 1ns / 1ps

module bba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/bba_zero_find.sv @@
`timescale 1ns / 1ps

module bba_zero_find import bba_pkg::*; (
   input  logic [LANE_W-1:0]     vec,
   output logic                  found,
   output logic [LANE_IDX_W-1:0] pos
);

   // lowest clear bit wins
   always_comb begin
      found = 1'b0;
      pos   = '0;
      for (int i = LANE_W - 1; i >= 0; i--) begin
         if (!vec[i]) begin
            found = 1'b1;
            pos   = LANE_IDX_W'(i);
         end
      end
   end

endmodule

@@ hw/rtl/bba_seq.sv @@
`timescale 1ns / 1ps

module bba_seq import bba_pkg::*; #(
   parameter int MAX_BLOCKS = 4096,
   localparam int WORDS  = (MAX_BLOCKS + WORD_W - 1) / WORD_W,
   localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1,
   localparam int LIM_W  = $clog2(MAX_BLOCKS + 1),
   localparam int CMP_A  = (LIM_W > CNT_W) ? LIM_W : CNT_W,
   localparam int CMP_W  = (CMP_A > ADDR_W + BIT_IDX_W) ? CMP_A : ADDR_W + BIT_IDX_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_cmd,
   input  logic [BLK_W-1:0]  req_idx,
   input  logic [CMP_W-1:0]  cnt_lim,
   input  logic              out_free,
   output logic              resp_load,
   output resp_type          resp,
   output logic              ram_rd_en,
   output logic [ADDR_W-1:0] ram_rd_addr,
   input  logic [WORD_W-1:0] ram_rd_data,
   output logic              ram_wr_en,
   output logic [ADDR_W-1:0] ram_wr_addr,
   output logic [WORD_W-1:0] ram_wr_data
);

   localparam int GROUPS = (WORDS + LANE_W - 1) / LANE_W;
   localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int FLAG_N = GROUPS * LANE_W;

   state_type                state_ff, state_in;
   logic [GRP_W-1:0]         grp_ff, grp_in;
   logic [LANE_IDX_W-1:0]    lane_ff, lane_in;
   logic [ADDR_W-1:0]        waddr_ff, waddr_in;
   logic [BIT_IDX_W-1:0]     bit_ff, bit_in;
   logic [WORDS-1:0]         full_ff, full_in;
   resp_type                 resp_ff, resp_in;

   logic [FLAG_N-1:0]        sum_flags;
   logic [LANE_W-1:0]        zf_vec;
   logic                     zf_found;
   logic [LANE_IDX_W-1:0]    zf_pos;

   logic [CMP_W-1:0]         idx_ext;
   logic                     idx_out;
   logic [ADDR_W-1:0]        free_word;
   logic [ADDR_W-1:0]        scan_word;
   logic [CMP_W-1:0]         scan_base;
   logic                     base_out;
   logic                     grp_last;
   logic                     lane_last;
   logic [CMP_W-1:0]         found_idx;
   logic                     found_out;
   logic [WORD_W-1:0]        set_word;
   logic [WORD_W-1:0]        clr_word;
   logic                     bit_used;

   // rows past the end of the bitmap look full so the scan skips them
   for (genvar i = 0; i < FLAG_N; i++) begin : g_flags
      if (i < WORDS) begin : g_real
         assign sum_flags[i] = full_ff[i];
      end else begin : g_pad
         assign sum_flags[i] = 1'b1;
      end
   end

   always_comb begin
      zf_vec = ram_rd_data[lane_ff*LANE_W +: LANE_W];
      if (state_ff == ST_SCAN) begin
         zf_vec = sum_flags[grp_ff*LANE_W +: LANE_W];
      end
   end

   bba_zero_find u_find (
      .vec   (zf_vec),
      .found (zf_found),
      .pos   (zf_pos)
   );

   assign idx_ext   = CMP_W'(req_idx);
   assign idx_out   = (idx_ext >= cnt_lim);
   assign free_word = idx_ext[ADDR_W+BIT_IDX_W-1:BIT_IDX_W];
   assign scan_word = ADDR_W'({grp_ff, zf_pos});
   assign scan_base = CMP_W'({scan_word, {BIT_IDX_W{1'b0}}});
   assign base_out  = (scan_base >= cnt_lim);
   assign grp_last  = (grp_ff == GRP_W'(GROUPS - 1));
   assign lane_last = (lane_ff == LANE_IDX_W'(LANE_W - 1));
   assign found_idx = CMP_W'({waddr_ff, lane_ff, zf_pos});
   assign found_out = (found_idx >= cnt_lim);
   assign set_word  = ram_rd_data | (WORD_W'(1) << {lane_ff, zf_pos});
   assign clr_word  = ram_rd_data & ~(WORD_W'(1) << bit_ff);
   assign bit_used  = ram_rd_data[bit_ff];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (waddr_ff == ADDR_W'(WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_cmd == CMD_ALLOC) begin
                  state_in = ST_SCAN;
               end else if (idx_out) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_FCHECK;
               end
            end
         end
         ST_SCAN: begin
            if (zf_found) begin
               state_in = base_out ? ST_DONE : ST_WORD;
            end else if (grp_last) begin
               state_in = ST_DONE;
            end
         end
         ST_WORD: begin
            if (zf_found || lane_last) begin
               state_in = ST_DONE;
            end
         end
         ST_FCHECK: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // handshake and memory control
   always_comb begin
      req_ready   = 1'b0;
      resp_load   = 1'b0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = scan_word;
      ram_wr_en   = 1'b0;
      ram_wr_addr = waddr_ff;
      ram_wr_data = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en = 1'b1;
         end
         ST_IDLE: begin
            req_ready   = 1'b1;
            ram_rd_addr = free_word;
            ram_rd_en   = req_valid && (req_cmd == CMD_FREE) && !idx_out;
         end
         ST_SCAN: begin
            ram_rd_en = zf_found && !base_out;
         end
         ST_WORD: begin
            ram_wr_en   = zf_found && !found_out;
            ram_wr_data = set_word;
         end
         ST_FCHECK: begin
            ram_wr_en   = bit_used;
            ram_wr_data = clr_word;
         end
         ST_DONE: begin
            resp_load = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      grp_in   = grp_ff;
      lane_in  = lane_ff;
      waddr_in = waddr_ff;
      bit_in   = bit_ff;
      full_in  = full_ff;
      resp_in  = resp_ff;
      case (state_ff)
         ST_CLEAR: begin
            waddr_in = waddr_ff + 1'b1;
         end
         ST_IDLE: begin
            grp_in   = '0;
            bit_in   = idx_ext[BIT_IDX_W-1:0];
            waddr_in = free_word;
            resp_in  = '{status: STAT_OK, granted: '0};
            if (req_cmd == CMD_FREE && idx_out) begin
               resp_in.status = STAT_RANGE;
            end
         end
         ST_SCAN: begin
            if (zf_found) begin
               waddr_in = scan_word;
               lane_in  = '0;
               if (base_out) begin
                  resp_in.status = STAT_NO_FREE;
               end
            end else begin
               grp_in = grp_ff + 1'b1;
               if (grp_last) begin
                  resp_in.status = STAT_NO_FREE;
               end
            end
         end
         ST_WORD: begin
            if (zf_found) begin
               if (found_out) begin
                  resp_in.status = STAT_NO_FREE;
               end else begin
                  resp_in.granted  = found_idx[BLK_W-1:0];
                  full_in[waddr_ff] = &set_word;
               end
            end else begin
               lane_in = lane_ff + 1'b1;
               if (lane_last) begin
                  resp_in.status = STAT_NO_FREE;
               end
            end
         end
         ST_FCHECK: begin
            if (bit_used) begin
               full_in[waddr_ff] = 1'b0;
            end else begin
               resp_in.status = STAT_DOUBLE_FREE;
            end
         end
         default: begin
            resp_in = resp_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         waddr_ff <= '0;
         full_ff  <= '0;
      end else begin
         state_ff <= state_in;
         waddr_ff <= waddr_in;
         full_ff  <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      grp_ff  <= grp_in;
      lane_ff <= lane_in;
      bit_ff  <= bit_in;
      resp_ff <= resp_in;
   end

   assign resp = resp_ff;

endmodule

@@ hw/rtl/bitmap_block_allocator_unit.sv @@
`timescale 1ns / 1ps

// First-fit block allocator over a used/free bitmap.
// req_ channel: one beat per request, either allocate the lowest free block
// or free a named block. rsp_ channel: exactly one beat per request, carrying
// the granted block and a status (ok, no free block, double free, out of
// range). csr_: block_count, the number of blocks in use (capped at
// MAX_BLOCKS); write it only while no request is in flight.
// The bitmap sits in a 64-bit wide memory with a full flag per row. An
// allocate scans the full flags eight at a time, then the chosen row a byte
// at a time, both through one 8-bit zero finder. A free reads its row, then
// checks and clears the bit; an out-of-range free goes straight to the result
// state, where each result waits until the output register is free.
// One request is in flight at a time; the next beat is taken the cycle after
// the previous result is handed to the output register.
// Reset: the memory is swept to zero, one row a cycle, with req_tready low;
// block_count returns to 4096. A stalled receiver holds rsp_tdata steady;
// a finished result waits in the output register while the next request
// is already being worked on.
module bitmap_block_allocator_unit import bba_pkg::*; #(
   parameter int MAX_BLOCKS = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [TDATA_W-1:0] req_tdata,   // [0] command, [12:1] block_index
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata,   // [11:0] granted_index, [13:12] status
   input  logic               csr_wr_en,
   input  logic [CNT_W-1:0]   csr_wr_data
);

   localparam int WORDS  = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
   localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int LIM_W  = $clog2(MAX_BLOCKS + 1);
   localparam int CMP_A  = (LIM_W > CNT_W) ? LIM_W : CNT_W;
   localparam int CMP_W  = (CMP_A > ADDR_W + BIT_IDX_W) ? CMP_A : ADDR_W + BIT_IDX_W;
   localparam logic [CMP_W-1:0] MAX_LIM = CMP_W'(MAX_BLOCKS);

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CMP_W-1:0]  count_ext;
   logic [CMP_W-1:0]  cnt_lim;
   logic              rsp_valid_ff, rsp_valid_in;
   resp_type          rsp_ff;
   resp_type          seq_resp;
   logic              resp_load;
   logic              out_free;

   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [WORD_W-1:0] ram_rd_data;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [WORD_W-1:0] ram_wr_data;

   assign count_in  = csr_wr_en ? csr_wr_data : count_ff;
   assign count_ext = CMP_W'(count_ff);
   assign cnt_lim   = (count_ext > MAX_LIM) ? MAX_LIM : count_ext;

   assign out_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (resp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= CNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (resp_load) begin
         rsp_ff <= seq_resp;
      end
   end

   bba_seq #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_cmd     (req_tdata[0]),
      .req_idx     (req_tdata[BLK_W:1]),
      .cnt_lim     (cnt_lim),
      .out_free    (out_free),
      .resp_load   (resp_load),
      .resp        (seq_resp),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data)
   );

   bba_ram #(
      .WIDTH (WORD_W),
      .DEPTH (WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_W'(rsp_ff);

endmodule

@@ hw/rtl/bba_checker.sv @@
`timescale 1ns / 1ps

module bba_checker import bba_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_tvalid,
   input logic               req_tready,
   input logic               rsp_tvalid,
   input logic               rsp_tready,
   input logic [TDATA_W-1:0] rsp_tdata
);

   // memory sweep keeps requests out straight after reset
   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !req_tready)
      else $error("request taken during clearing sweep");

   // one request in flight: a taken beat drops ready
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second request taken while one is in flight");

   // only a successful allocate carries a block number
   a_grant_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[13:12] != 2'(STAT_OK)) |-> (rsp_tdata[11:0] == '0))
      else $error("block number on a failed request");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("response beat changed while stalled");

endmodule

bind bitmap_block_allocator_unit bba_checker u_bba_checker (.*);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

import bba_pkg::*;

// Tracks the used/free map alongside the block and holds the responses
// still owed, oldest first.
class bitmap_tracker;
   localparam int CAPACITY = 4096;

   bit          used_map [0:CAPACITY-1];
   int unsigned live_blocks;
   resp_type    due_responses [$];
   int          errors;

   function new();
      foreach (used_map[b]) used_map[b] = 1'b0;
      live_blocks = CNT_RESET;
      errors      = 0;
   endfunction

   function void set_block_count(logic [CNT_W-1:0] value);
      live_blocks = (value > CAPACITY) ? CAPACITY : value;
   endfunction

   function int pending();
      return due_responses.size();
   endfunction

   // random block that is currently held, or -1 if none below the count
   function int pick_used();
      int start, k, b;
      if (live_blocks == 0) return -1;
      start = $urandom_range(0, live_blocks - 1);
      for (k = 0; k < live_blocks; k++) begin
         b = (start + k) % live_blocks;
         if (used_map[b]) return b;
      end
      return -1;
   endfunction

   function void note_request(logic cmd, logic [BLK_W-1:0] idx);
      resp_type exp;
      bit       found;
      int       b;
      exp.granted = '0;
      exp.status  = STAT_OK;
      found       = 1'b0;
      if (cmd == CMD_ALLOC) begin
         // first fit: lowest clear bit below the live count
         for (b = 0; b < live_blocks && !found; b++) begin
            if (!used_map[b]) begin
               used_map[b] = 1'b1;
               exp.granted = b[BLK_W-1:0];
               found       = 1'b1;
            end
         end
         if (!found) exp.status = STAT_NO_FREE;
      end else if (int'(idx) >= live_blocks) begin
         exp.status = STAT_RANGE;
      end else if (!used_map[idx]) begin
         exp.status = STAT_DOUBLE_FREE;
      end else begin
         used_map[idx] = 1'b0;
      end
      due_responses.push_back(exp);
   endfunction

   function void check_result(logic [TDATA_W-1:0] data);
      resp_type exp, got;
      got = resp_type'(data[STAT_W+BLK_W-1:0]);
      if (due_responses.size() == 0) begin
         $error("response beat with nothing outstanding: tdata 0x%0h", data);
         errors++;
         return;
      end
      exp = due_responses.pop_front();
      if (got.granted !== exp.granted) begin
         $error("granted_index mismatch: expected %0d, actual %0d", exp.granted, got.granted);
         errors++;
      end
      if (got.status !== exp.status) begin
         $error("status mismatch: expected %0d, actual %0d", exp.status, got.status);
         errors++;
      end
   endfunction
endclass

module tb_top;
   localparam int MAX_BLOCKS     = 4096;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 24;
   localparam int PHASE_ITEMS    = 75;

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_tvalid  = 1'b0;
   logic               req_tready;
   logic [TDATA_W-1:0] req_tdata   = '0;   // [0] command, [12:1] block_index
   logic               rsp_tvalid;
   logic               rsp_tready  = 1'b0;
   logic [TDATA_W-1:0] rsp_tdata;          // [11:0] granted_index, [13:12] status
   logic               csr_wr_en   = 1'b0;
   logic [CNT_W-1:0]   csr_wr_data = '0;

   bitmap_tracker tracker;
   bit            no_idle   = 1'b0;
   bit            hold_done = 1'b0;
   int            rsp_beats = 0;
   int            quiet_cycles = 0;

   int phase_counts [10] = '{5, 64, 1, 130, 0, 4096, 17, 512, 2, 4095};

   bitmap_block_allocator_unit #(.MAX_BLOCKS(MAX_BLOCKS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         tracker.check_result(rsp_tdata);
         rsp_beats++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL bitmap_block_allocator_unit");
         $finish;
      end
   end

   // receiver: random back-pressure, plus one long hold-off to fill the block
   initial begin
      forever begin
         @(negedge clock);
         if (!hold_done && rsp_beats >= 250) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_tready <= no_idle || ($urandom_range(0, 99) >= 28);
      end
   end

   task automatic send_request(input logic cmd, input logic [BLK_W-1:0] idx);
      @(negedge clock);
      while (!no_idle && $urandom_range(0, 99) < 28) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(TDATA_W-BLK_W-1){1'b0}}, idx, cmd};
      do @(posedge clock); while (!req_tready);
      tracker.note_request(cmd, idx);
   endtask

   // drain every outstanding beat, let the block settle, then write the count
   task automatic set_block_count(input logic [CNT_W-1:0] value);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      tracker.set_block_count(value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_phase(input int count_val, input int n_items);
      logic [BLK_W-1:0] idx;
      int               pick, k, bound;
      set_block_count(count_val[CNT_W-1:0]);
      for (int i = 0; i < n_items; i++) begin
         // fill first, then drain, so the map hits full and near empty
         if ($urandom_range(0, 99) < ((i < n_items / 2) ? 75 : 30)) begin
            send_request(CMD_ALLOC, BLK_W'($urandom_range(0, MAX_BLOCKS - 1)));
         end else begin
            k     = $urandom_range(0, 9);
            pick  = tracker.pick_used();
            bound = (count_val + 2 > MAX_BLOCKS - 1) ? MAX_BLOCKS - 1 : count_val + 2;
            if (k < 6 && pick >= 0)
               idx = pick[BLK_W-1:0];
            else if (k < 8)
               idx = BLK_W'($urandom_range(0, bound));
            else
               idx = BLK_W'($urandom_range(0, MAX_BLOCKS - 1));
            send_request(CMD_FREE, idx);
         end
      end
   endtask

   initial begin
      tracker = new();
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed: first fit, double free, range edges, zero and oversize count
      send_request(CMD_ALLOC, 12'd4095);
      send_request(CMD_ALLOC, 12'd0);
      send_request(CMD_FREE, 12'd1);
      send_request(CMD_FREE, 12'd1);
      send_request(CMD_FREE, 12'd4095);
      send_request(CMD_FREE, 12'd0);
      send_request(CMD_ALLOC, 12'd0);
      send_request(CMD_ALLOC, 12'd0);
      set_block_count(13'd0);
      send_request(CMD_ALLOC, 12'd0);
      send_request(CMD_FREE, 12'd0);
      send_request(CMD_FREE, 12'd4095);
      set_block_count(13'd8191);
      send_request(CMD_FREE, 12'd4095);
      send_request(CMD_ALLOC, 12'd0);
      set_block_count(13'd3);
      send_request(CMD_ALLOC, 12'd0);
      send_request(CMD_FREE, 12'd2);
      send_request(CMD_ALLOC, 12'd0);
      send_request(CMD_FREE, 12'd3);
      set_block_count(13'd1);
      send_request(CMD_ALLOC, 12'd0);
      send_request(CMD_FREE, 12'd0);
      send_request(CMD_ALLOC, 12'd0);

      foreach (phase_counts[p]) begin
         no_idle = (phase_counts[p] == 4096);
         run_phase(phase_counts[p], (phase_counts[p] == 0) ? 20 : PHASE_ITEMS);
      end
      no_idle = 1'b0;

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.errors == 0)
         $display("PASS bitmap_block_allocator_unit");
      else
         $display("FAIL bitmap_block_allocator_unit");
      $finish;
   end
endmodule
